// File: hw/rtl/rms_pkg.sv
// Shared types, constants and codes for the rolling mean / standard deviation block.
package rms_pkg;

  // Field widths of one request and one result
  localparam int unsigned PRICE_W = 24;
  localparam int unsigned DAY_W   = 27;
  localparam int unsigned TOD_W   = 18;
  localparam int unsigned MS_W    = 10;
  localparam int unsigned TS_W    = 57;
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned LEN_W   = 9;

  // Accumulator and arithmetic widths
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned SQ_W   = 56;
  localparam int unsigned SQ_HW  = SQ_W / 2;
  localparam int unsigned VAR_W  = 64;
  localparam int unsigned ROOT_W = VAR_W / 2;

  // Timestamp packing scales
  localparam longint unsigned DAY_SCALE = 64'd1000000000;
  localparam longint unsigned TOD_SCALE = 64'd1000;

  // Register reset value and parameter defaults
  localparam logic [LEN_W-1:0] WIN_LEN_RESET   = 9'd30;
  localparam int unsigned      DEF_MAX_WINDOW  = 256;
  localparam int unsigned      DEF_PRICE_BITS  = 24;

  // Configuration register index (word address bit 2)
  typedef enum logic {
    REG_WINDOW_LENGTH = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [DAY_W-1:0]   trading_day;
    logic [TOD_W-1:0]   time_of_day;
    logic [MS_W-1:0]    millisec;
    logic               first_of_series;
  } in_req_t;

  typedef struct packed {
    logic [TS_W-1:0]  timestamp;
    logic [OUT_W-1:0] mean_price;
    logic [OUT_W-1:0] std_dev;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SQUARE,
    ST_UPDATE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_VAR,
    ST_START,
    ST_ROOT,
    ST_SD_START,
    ST_SD_DIV,
    ST_EMIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic fetch;
    logic square;
    logic update;
    logic mul_lo;
    logic mul_hi;
    logic add_a;
    logic clamp;
    logic start_root;
    logic start_sd;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit;
    logic root_done;
    logic div_done;
    logic out_full;
  } sts_t;

endpackage

// File: hw/rtl/rms_div.sv
// Restoring divider, one quotient bit per cycle.
module rms_div
  import rms_pkg::*;
#(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quot_o,
  output logic          done_o
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] den_q;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW:0]   rem_sh;
  logic          ge;

  // One compare and subtract a step
  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_d  = ge ? VW'(rem_sh - {1'b0, den_q}) : rem_sh[VW-1:0];
    quo_d  = {quo_q[DW-2:0], ge};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) busy_q <= 1'b0;
    end
  end

  // Operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = quo_q;
  assign done_o = !busy_q;

endmodule

// File: hw/rtl/rms_sqrt.sv
// Floor square root, one root bit per cycle.
module rms_sqrt
  import rms_pkg::*;
#(
  parameter int unsigned XW = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [XW-1:0]   rad_i,
  output logic [XW/2-1:0] root_o,
  output logic            done_o
);

  localparam int unsigned RW = XW / 2;
  localparam int unsigned MW = RW + 4;
  localparam int unsigned CW = $clog2(RW);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [XW-1:0] x_q;
  logic [RW-1:0] root_q, root_d;
  logic [MW-1:0] rem_q, rem_d;
  logic [MW-1:0] rem_sh, trial;
  logic          ge;

  // Bring down two bits, try root*4+1
  always_comb begin
    rem_sh = {rem_q[MW-3:0], x_q[XW-1:XW-2]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = rem_sh >= trial;
    rem_d  = ge ? rem_sh - trial : rem_sh;
    root_d = {root_q[RW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(RW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[XW-3:0], 2'b00};
      root_q <= root_d;
      rem_q  <= rem_d;
    end
  end

  assign root_o = root_q;
  assign done_o = !busy_q;

endmodule

// File: hw/rtl/rms_ctrl.sv
// Sequencing state machine for the rolling statistics datapath.
module rms_ctrl
  import rms_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_FETCH;
      ST_FETCH:    state_d = ST_SQUARE;
      ST_SQUARE:   state_d = ST_UPDATE;
      ST_UPDATE:   state_d = sts_i.emit ? ST_MUL_LO : ST_IDLE;
      ST_MUL_LO:   state_d = ST_MUL_HI;
      ST_MUL_HI:   state_d = ST_ADD;
      ST_ADD:      state_d = ST_VAR;
      ST_VAR:      state_d = ST_START;
      ST_START:    state_d = ST_ROOT;
      ST_ROOT:     if (sts_i.root_done && sts_i.div_done) state_d = ST_SD_START;
      ST_SD_START: state_d = ST_SD_DIV;
      ST_SD_DIV:   if (sts_i.div_done) state_d = ST_EMIT;
      ST_EMIT:     if (!sts_i.out_full) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_FETCH:    cmd_o.fetch      = 1'b1;
      ST_SQUARE:   cmd_o.square     = 1'b1;
      ST_UPDATE:   cmd_o.update     = 1'b1;
      ST_MUL_LO:   cmd_o.mul_lo     = 1'b1;
      ST_MUL_HI:   cmd_o.mul_hi     = 1'b1;
      ST_ADD:      cmd_o.add_a      = 1'b1;
      ST_VAR:      cmd_o.clamp      = 1'b1;
      ST_START:    cmd_o.start_root = 1'b1;
      ST_SD_START: cmd_o.start_sd   = 1'b1;
      ST_EMIT:     cmd_o.load_out   = !sts_i.out_full;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/rms_dp.sv
// Datapath: price ring, running sums, variance, root and divide, result register.
module rms_dp
  import rms_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int unsigned PRICE_BITS = DEF_PRICE_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_req_t          in_req_i,
  input  logic [LEN_W-1:0] len_i,
  input  logic             cfg_clear_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_req_t         out_req_o
);

  localparam int unsigned AW = $clog2(MAX_WINDOW);
  localparam int unsigned IW = LEN_W + 1;
  localparam int unsigned PW = 2 * PRICE_BITS;
  localparam int unsigned LW = LEN_W + SQ_HW;

  // Captured request
  logic [PRICE_BITS-1:0] p_q;
  logic [DAY_W-1:0]      day_q;
  logic [TOD_W-1:0]      tod_q;
  logic [MS_W-1:0]       ms_q;

  // Window state
  logic [PRICE_BITS-1:0] ring_q [MAX_WINDOW];
  logic [PRICE_BITS-1:0] rd_q;
  logic [AW-1:0]         wp_q;
  logic [LEN_W-1:0]      fill_q;
  logic [SUM_W-1:0]      sum_q;
  logic [SQ_W-1:0]       sq_q;
  logic                  full_q;

  // Intermediate results
  logic [TS_W-1:0]  day_prod_q, ts_q;
  logic [TS_W-1:0]  tod_prod_q;
  logic [PW-1:0]    old_sq_q, new_sq_q;
  logic [LW-1:0]    prod_lo_q, prod_hi_q;
  logic [VAR_W-1:0] bsq_q, a_q, var_q;
  logic [OUT_W-1:0] mean_q;
  logic             out_valid_q;
  out_req_t         out_q;

  logic [IW-1:0]         wp_w, len_w, old_w;
  logic [AW-1:0]         old_idx, wp_next;
  logic [PRICE_BITS-1:0] old_val;
  logic [LEN_W-1:0]      fill_next;
  logic [ROOT_W-1:0]     root;
  logic [SUM_W-1:0]      quot, div_arg;
  logic                  root_done, div_done;

  // Oldest entry index, modulo the ring depth
  always_comb begin
    wp_w    = IW'(wp_q);
    len_w   = IW'(len_i);
    old_w   = (wp_w >= len_w) ? wp_w - len_w : wp_w + IW'(MAX_WINDOW) - len_w;
    old_idx = old_w[AW-1:0];
    wp_next = (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
    old_val = full_q ? rd_q : '0;
    fill_next = full_q ? fill_q : fill_q + 1'b1;
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      p_q   <= in_req_i.price[PRICE_BITS-1:0];
      day_q <= in_req_i.trading_day;
      tod_q <= in_req_i.time_of_day;
      ms_q  <= in_req_i.millisec;
    end
  end

  // Price ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.square) ring_q[wp_q] <= p_q;
    if (cmd_i.fetch)  rd_q <= ring_q[old_idx];
  end

  // Window control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      full_q <= 1'b0;
    end else if (cfg_clear_i || (cmd_i.capture && in_req_i.first_of_series)) begin
      wp_q   <= '0;
      fill_q <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
    end else begin
      if (cmd_i.fetch) full_q <= fill_q >= len_i;
      if (cmd_i.update) begin
        sum_q  <= sum_q + SUM_W'(p_q) - SUM_W'(old_val);
        sq_q   <= sq_q + SQ_W'(new_sq_q) - SQ_W'(old_sq_q);
        fill_q <= fill_next;
        wp_q   <= wp_next;
      end
    end
  end

  // Products, variance and timestamp
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      day_prod_q <= TS_W'(day_q) * TS_W'(DAY_SCALE);
      tod_prod_q <= TS_W'(tod_q) * TS_W'(TOD_SCALE);
    end
    if (cmd_i.square) begin
      old_sq_q <= PW'(old_val) * PW'(old_val);
      new_sq_q <= PW'(p_q) * PW'(p_q);
      ts_q     <= day_prod_q + tod_prod_q + TS_W'(ms_q);
    end
    if (cmd_i.mul_lo) begin
      prod_lo_q <= LW'(len_i) * LW'(sq_q[SQ_HW-1:0]);
      bsq_q     <= VAR_W'(sum_q) * VAR_W'(sum_q);
    end
    if (cmd_i.mul_hi) prod_hi_q <= LW'(len_i) * LW'(sq_q[SQ_W-1:SQ_HW]);
    if (cmd_i.add_a)  a_q <= VAR_W'(prod_lo_q) + (VAR_W'(prod_hi_q) << SQ_HW);
    if (cmd_i.clamp)  var_q <= (a_q > bsq_q) ? a_q - bsq_q : '0;
    if (cmd_i.start_sd) mean_q <= quot[OUT_W-1:0];
  end

  // Iterative units; the divider serves the mean then the deviation
  assign div_arg = cmd_i.start_sd ? SUM_W'(root) : sum_q;

  rms_sqrt #(.XW(VAR_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_root),
    .rad_i   (var_q),
    .root_o  (root),
    .done_o  (root_done)
  );

  rms_div #(.DW(SUM_W), .VW(LEN_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_root || cmd_i.start_sd),
    .dividend_i (div_arg),
    .divisor_i  (len_i),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.timestamp  <= ts_q;
      out_q.mean_price <= mean_q;
      out_q.std_dev    <= quot[OUT_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_req_o       = out_q;
  assign sts_o.emit      = fill_next == len_i;
  assign sts_o.root_done = root_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_full  = out_valid_q;

endmodule

// File: hw/rtl/rolling_mean_stddev_top.sv
// Rolling mean and standard deviation top level with configuration port.
// A tick that gives no result passes FETCH, SQUARE and UPDATE before the next request.
// A tick that gives a result also runs the products and variance, the mean divide
// beside the 32-step root, then the 32-step deviation divide, and the next request is
// taken once the result is loaded. A waiting result holds the next result back meanwhile.
// Reset is asynchronous, active low: window empty, window_length back to 30.
module rolling_mean_stddev_top
  import rms_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int unsigned PRICE_BITS = DEF_PRICE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_req_t    out_req_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LEN_W-1:0] win_len_q;
  logic [LEN_W-1:0] len_eff;
  logic             cfg_wr, win_we;
  cmd_t             cmd;
  sts_t             sts;

  // Register write decode
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign win_we = cfg_wr && (paddr[2] == REG_WINDOW_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)     win_len_q <= WIN_LEN_RESET;
    else if (win_we) win_len_q <= pwdata[LEN_W-1:0];
  end

  assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? 32'(win_len_q) : '0;

  // Effective length: zero reads as one, clipped to the ring depth
  always_comb begin
    if (win_len_q == '0)                        len_eff = LEN_W'(1);
    else if (win_len_q > LEN_W'(MAX_WINDOW))    len_eff = LEN_W'(MAX_WINDOW);
    else                                        len_eff = win_len_q;
  end

  rms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rms_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .len_i       (len_eff),
    .cfg_clear_i (win_we),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // One tick at a time: an accepted request blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in work");

  // A window_length write lands in the register
  a_len_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_we |=> win_len_q == $past(pwdata[LEN_W-1:0]))
    else $error("window_length write lost");

  // Effective length stays within one and the ring depth
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_eff != '0 && len_eff <= LEN_W'(MAX_WINDOW))
    else $error("effective window length out of range");

endmodule
